>>> rtl/klx_pkg.sv
// ----------------------------------------------------------------------------
// klx_pkg
// Types and constants shared by the keyword lexer's front end, token queue
// and back end.
// ----------------------------------------------------------------------------
package klx_pkg;

	// Lexeme limits
	localparam int MAX_LEXEME    = 32;
	localparam int KEYWORD_CHARS = 5;
	localparam int LEN_W         = $clog2(MAX_LEXEME + 1);
	localparam int OUT_LEN_W     = 6;

	// Keyword registers
	localparam int KW_W      = 40;
	localparam int KW_BYTES  = KW_W / 8;
	localparam int KW_COUNT  = 4;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_KW_BEGIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KW_END   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KW_READ  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KW_WRITE = 3'd3;

	localparam logic [KW_W-1:0] KW_BEGIN_RST = 40'h424547494E;
	localparam logic [KW_W-1:0] KW_END_RST   = 40'h454E440000;
	localparam logic [KW_W-1:0] KW_READ_RST  = 40'h5245414400;
	localparam logic [KW_W-1:0] KW_WRITE_RST = 40'h5752495445;

	// Token queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Characters with a role of their own
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CASE_GAP  = 8'h20;

	typedef enum logic [3:0] {
		TK_BEGIN  = 4'd0,
		TK_END    = 4'd1,
		TK_READ   = 4'd2,
		TK_WRITE  = 4'd3,
		TK_ID     = 4'd4,
		TK_INTLIT = 4'd5,
		TK_LPAREN = 4'd6,
		TK_RPAREN = 4'd7,
		TK_SEMI   = 4'd8,
		TK_COMMA  = 4'd9,
		TK_ASSIGN = 4'd10,
		TK_PLUS   = 4'd11,
		TK_MINUS  = 4'd12,
		TK_EOF    = 4'd13,
		TK_ERROR  = 4'd14
	} token_kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_IDENT   = 3'd1,
		MODE_INTLIT  = 3'd2,
		MODE_COLON   = 3'd3,
		MODE_MINUS   = 3'd4,
		MODE_COMMENT = 3'd5
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [3:0]           token_kind;
		logic [OUT_LEN_W-1:0] lexeme_length;
		logic [7:0]           bad_char;
		logic                 last_in_run;
	} out_item_t;

	// Tokens caused by one character: the first may be a word needing a
	// keyword check, the second never is.
	typedef struct packed {
		logic                          two;
		token_kind_t                   kind0;
		logic                          word0;
		logic [LEN_W-1:0]              len0;
		logic [7:0]                    bad0;
		logic [KEYWORD_CHARS-1:0][7:0] prefix;
		logic                          too_long;
		token_kind_t                   kind1;
		logic [7:0]                    bad1;
	} tok_bundle_t;

endpackage

>>> rtl/klx_front.sv
// ----------------------------------------------------------------------------
// klx_front
// Character scanner: takes one character per cycle unless the queue is full,
// tracks the pending token and pushes the tokens of each character as one bundle.
// ----------------------------------------------------------------------------
module klx_front import klx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_ready,
	input  in_item_t    src_item,
	input  logic        q_full,
	output logic        q_push,
	output tok_bundle_t q_data
);

	scan_mode_t                    mode_q, mode_d;
	logic [KEYWORD_CHARS-1:0][7:0] prefix_q, prefix_d;
	logic [LEN_W-1:0]              count_q, count_d;
	logic                          too_long_q, too_long_d;

	logic [7:0]  c, c_up;
	logic        eoi, accept;
	logic        is_upper, is_lower, is_alpha, is_digit, is_word, is_space;

	logic        idle_emit, idle_start;
	token_kind_t idle_kind;
	logic [7:0]  idle_bad;
	scan_mode_t  idle_mode;

	logic        t0_v, t1_v, t0_word, grow, start, use_idle;
	token_kind_t t0_kind, t1_kind;
	logic [7:0]  t0_bad, t1_bad;
	logic [LEN_W-1:0] t0_len;

	assign c   = src_item.ch;
	assign eoi = src_item.end_of_input;

	// Classify the character
	assign is_upper = (c >= CH_UP_A) && (c <= CH_UP_Z);
	assign is_lower = (c >= CH_LO_A) && (c <= CH_LO_Z);
	assign is_alpha = is_upper || is_lower;
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign is_word  = is_alpha || is_digit || (c == CH_USCORE);
	assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	assign c_up     = is_lower ? (c - CASE_GAP) : c;

	assign src_ready = !q_full;
	assign accept    = src_valid && src_ready;

	// Scan a character from the idle state
	always_comb begin
		idle_emit  = 1'b0;
		idle_kind  = TK_EOF;
		idle_bad   = '0;
		idle_mode  = MODE_IDLE;
		idle_start = 1'b0;
		priority if (eoi) begin
			idle_emit = 1'b1;
		end else if (is_space) begin
			idle_emit = 1'b0;
		end else if (is_alpha) begin
			idle_mode  = MODE_IDENT;
			idle_start = 1'b1;
		end else if (is_digit) begin
			idle_mode  = MODE_INTLIT;
			idle_start = 1'b1;
		end else if (c == CH_LPAREN) begin
			idle_emit = 1'b1;
			idle_kind = TK_LPAREN;
		end else if (c == CH_RPAREN) begin
			idle_emit = 1'b1;
			idle_kind = TK_RPAREN;
		end else if (c == CH_SEMI) begin
			idle_emit = 1'b1;
			idle_kind = TK_SEMI;
		end else if (c == CH_COMMA) begin
			idle_emit = 1'b1;
			idle_kind = TK_COMMA;
		end else if (c == CH_PLUS) begin
			idle_emit = 1'b1;
			idle_kind = TK_PLUS;
		end else if (c == CH_COLON) begin
			idle_mode = MODE_COLON;
		end else if (c == CH_MINUS) begin
			idle_mode = MODE_MINUS;
		end else begin
			idle_emit = 1'b1;
			idle_kind = TK_ERROR;
			idle_bad  = c;
		end
	end

	// Close or extend the pending token
	always_comb begin
		t0_v     = 1'b0;
		t0_kind  = TK_EOF;
		t0_bad   = '0;
		t0_word  = 1'b0;
		t0_len   = '0;
		t1_v     = 1'b0;
		t1_kind  = TK_EOF;
		t1_bad   = '0;
		mode_d   = mode_q;
		grow     = 1'b0;
		start    = 1'b0;
		use_idle = 1'b0;
		unique case (mode_q)
			MODE_IDENT, MODE_INTLIT: begin
				if (!eoi && is_word) begin
					grow = 1'b1;
				end else begin
					t0_v     = 1'b1;
					t0_kind  = (mode_q == MODE_INTLIT) ? TK_INTLIT : TK_ID;
					t0_word  = (mode_q == MODE_IDENT);
					t0_len   = count_q;
					use_idle = 1'b1;
				end
			end
			MODE_COLON: begin
				t0_v = 1'b1;
				if (!eoi && c == CH_EQUALS) begin
					t0_kind = TK_ASSIGN;
					mode_d  = MODE_IDLE;
				end else begin
					t0_kind  = TK_ERROR;
					t0_bad   = CH_COLON;
					use_idle = 1'b1;
				end
			end
			MODE_MINUS: begin
				if (!eoi && c == CH_MINUS) begin
					mode_d = MODE_COMMENT;
				end else begin
					t0_v     = 1'b1;
					t0_kind  = TK_MINUS;
					use_idle = 1'b1;
				end
			end
			MODE_COMMENT: begin
				if (eoi) begin
					t0_v    = 1'b1;
					t0_kind = TK_EOF;
					mode_d  = MODE_IDLE;
				end else if (c == CH_NL) begin
					mode_d = MODE_IDLE;
				end
			end
			default: begin
				t0_v    = idle_emit;
				t0_kind = idle_kind;
				t0_bad  = idle_bad;
				mode_d  = idle_mode;
				start   = idle_start;
			end
		endcase
		if (use_idle) begin
			t1_v    = idle_emit;
			t1_kind = idle_kind;
			t1_bad  = idle_bad;
			mode_d  = idle_mode;
			start   = idle_start;
		end
	end

	// Start or extend the word prefix
	always_comb begin
		prefix_d   = prefix_q;
		count_d    = count_q;
		too_long_d = too_long_q;
		if (start) begin
			prefix_d    = '0;
			prefix_d[0] = c_up;
			count_d     = LEN_W'(1);
			too_long_d  = 1'b0;
		end else if (grow) begin
			if (count_q >= LEN_W'(KEYWORD_CHARS)) begin
				too_long_d = 1'b1;
			end
			for (int i = 0; i < KEYWORD_CHARS; i++) begin
				if (count_q == LEN_W'(i)) begin
					prefix_d[i] = c_up;
				end
			end
			if (count_q < LEN_W'(MAX_LEXEME)) begin
				count_d = count_q + LEN_W'(1);
			end
		end
	end

	// Push the bundle
	assign q_push = accept && t0_v;
	always_comb begin
		q_data.two      = t0_v && t1_v;
		q_data.kind0    = t0_kind;
		q_data.word0    = t0_word;
		q_data.len0     = t0_len;
		q_data.bad0     = t0_bad;
		q_data.prefix   = prefix_q;
		q_data.too_long = too_long_q;
		q_data.kind1    = t1_kind;
		q_data.bad1     = t1_bad;
	end

	// Advance the scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			prefix_q   <= '0;
			count_q    <= '0;
			too_long_q <= 1'b0;
		end else if (accept) begin
			mode_q     <= mode_d;
			prefix_q   <= prefix_d;
			count_q    <= count_d;
			too_long_q <= too_long_d;
		end
	end

endmodule

>>> rtl/klx_queue.sv
// ----------------------------------------------------------------------------
// klx_queue
// Short FIFO of token bundles between the scanner and the token emitter.
// ----------------------------------------------------------------------------
module klx_queue import klx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  tok_bundle_t push_data,
	output logic        full,
	output logic        head_valid,
	output tok_bundle_t head,
	input  logic        pop
);

	tok_bundle_t       entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push, do_pop;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Store incoming bundles
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/klx_back.sv
// ----------------------------------------------------------------------------
// klx_back
// Token emitter: holds the keyword registers, resolves identifiers against
// them and hands out one token per cycle, unless tok_ready stalls it, through an output register.
// ----------------------------------------------------------------------------
module klx_back import klx_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KW_W-1:0]      cfg_data,
	input  logic                 head_valid,
	input  tok_bundle_t          head,
	output logic                 pop,
	output logic                 tok_valid,
	input  logic                 tok_ready,
	output out_item_t            tok_item
);

	logic [KW_W-1:0]     kw_q [KW_COUNT];
	logic [KW_COUNT-1:0] kw_hit;
	logic                phase_q;
	logic                out_valid_q;
	out_item_t           out_q, out_d;
	logic                load, take;
	token_kind_t         kind0;
	logic [LEN_W-1:0]    len0;

	// Write keyword registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kw_q[0] <= KW_BEGIN_RST;
			kw_q[1] <= KW_END_RST;
			kw_q[2] <= KW_READ_RST;
			kw_q[3] <= KW_WRITE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KW_BEGIN: kw_q[0] <= cfg_data;
				REG_KW_END:   kw_q[1] <= cfg_data;
				REG_KW_READ:  kw_q[2] <= cfg_data;
				REG_KW_WRITE: kw_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Compare the word prefix against every keyword, whole word only
	always_comb begin
		logic       same, any;
		logic [7:0] kb;
		for (int k = 0; k < KW_COUNT; k++) begin
			same = !head.too_long;
			any  = 1'b0;
			for (int i = 0; i < KEYWORD_CHARS; i++) begin
				if (KEYWORD_CHARS - 1 - i < KW_BYTES) begin
					kb = kw_q[k][8*(KEYWORD_CHARS-1-i) +: 8];
				end else begin
					kb = '0;
				end
				if (kb != head.prefix[i]) begin
					same = 1'b0;
				end
				if (kb != '0) begin
					any = 1'b1;
				end
			end
			kw_hit[k] = same && any;
		end
	end

	// Pick the first matching keyword
	always_comb begin
		kind0 = head.kind0;
		len0  = head.len0;
		if (head.word0) begin
			priority if (kw_hit[0]) begin
				kind0 = TK_BEGIN;
				len0  = '0;
			end else if (kw_hit[1]) begin
				kind0 = TK_END;
				len0  = '0;
			end else if (kw_hit[2]) begin
				kind0 = TK_READ;
				len0  = '0;
			end else if (kw_hit[3]) begin
				kind0 = TK_WRITE;
				len0  = '0;
			end else begin
				kind0 = head.kind0;
			end
		end
	end

	// Select the token for this phase of the bundle
	always_comb begin
		if (phase_q) begin
			out_d.token_kind    = head.kind1;
			out_d.lexeme_length = '0;
			out_d.bad_char      = head.bad1;
			out_d.last_in_run   = 1'b1;
		end else begin
			out_d.token_kind    = kind0;
			out_d.lexeme_length = OUT_LEN_W'(len0);
			out_d.bad_char      = head.bad0;
			out_d.last_in_run   = !head.two;
		end
	end

	assign load = !out_valid_q || tok_ready;
	assign take = load && head_valid;
	assign pop  = take && (phase_q || !head.two);

	// Hold the output token until taken
	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= head_valid;
			end
			if (take) begin
				phase_q <= !phase_q && head.two;
			end
		end
	end

	assign tok_valid = out_valid_q;
	assign tok_item  = out_q;

endmodule

>>> rtl/keyword_lexer.sv
// ----------------------------------------------------------------------------
// keyword_lexer
// Scanner for a small language: one source character in, tokens out, with
// case-insensitive whole-word keyword matching against four registers.
//
//   Channel   Direction   Handshake                Payload
//   src       in          src_valid / src_ready    in_item_t  (ch, end_of_input)
//   tok       out         tok_valid / tok_ready    out_item_t (one token)
//   cfg       in          cfg_we                   cfg_index, cfg_data
//
// One character is accepted per cycle while the queue has room; a character
// that closes a token and is itself a one-character token yields two tokens,
// which leave one after the other. A token passes a queue entry and then the
// output register. A four-bundle queue decouples the scanner from the emitter,
// so either side may stall on its own. Reset restores the keyword registers to
// BEGIN, END, READ and WRITE and leaves the scanner idle between tokens.
// ----------------------------------------------------------------------------
module keyword_lexer import klx_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_ready,
	input  in_item_t             src_item,
	output logic                 tok_valid,
	input  logic                 tok_ready,
	output out_item_t            tok_item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KW_W-1:0]      cfg_data
);

	logic        q_push, q_full, q_head_valid, q_pop;
	tok_bundle_t q_push_data, q_head;

	klx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_push_data)
	);

	klx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_push_data),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop)
	);

	klx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.tok_valid  (tok_valid),
		.tok_ready  (tok_ready),
		.tok_item   (tok_item)
	);

endmodule
